/* src/tach_pkg.sv */
// shared types and constants for the debounced period tachometer
// no dependencies; used by the channel interfaces and every tach_* module
package tach_pkg;

  // field widths
  localparam int unsigned SPD_W      = 24;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned DIV_W      = 26;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd2;

  // register reset values
  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd80;
  localparam logic [CNT_W-1:0] IDLE_RST     = 16'd1000;
  localparam logic [SPD_W-1:0] SCALE_RST    = 24'd6000000;

  // divisor used for the running average
  localparam logic [CNT_W-1:0] AVG_DIVISOR = 16'd3;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] idle_ticks;
    logic [SPD_W-1:0] speed_scale;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/tach_if.sv */
// valid/ready channel interfaces: input tick, result and configuration write
// depends on tach_pkg for the payload widths
interface tach_in_if;
  import tach_pkg::*;
  logic valid;
  logic ready;
  logic sensor_low;
  modport source (output valid, output sensor_low, input ready);
  modport sink (input valid, input sensor_low, output ready);
endinterface

interface tach_out_if;
  import tach_pkg::*;
  logic             valid;
  logic             ready;
  logic [SPD_W-1:0] speed_x100;
  logic [SPD_W-1:0] avg_speed_x100;
  logic             pulse_taken;
  logic             idle_hit;
  modport source (output valid, output speed_x100, output avg_speed_x100,
                  output pulse_taken, output idle_hit, input ready);
  modport sink (input valid, input speed_x100, input avg_speed_x100,
                input pulse_taken, input idle_hit, output ready);
endinterface

interface tach_cfg_if;
  import tach_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/tick_rpm_meter_debounced.sv */
// debounced period tachometer top level: sequencer, counters, result register
// depends on tach_pkg, tach_if, tach_cfg and tach_div
//
//  channel  dir  payload                                           transfer
//  in_ch    in   sensor_low                                        valid & ready
//  out_ch   out  speed_x100, avg_speed_x100, pulse_taken, idle_hit valid & ready
//  cfg_ch   in   index (0 debounce, 1 idle, 2 scale), data         valid & ready
//
// a tick without a pulse goes from the transfer through the final step to the result register
// a tick with a pulse first makes two passes of the serial divider
// (scale / period, then (2*avg + speed) / 3), then the final step
// the next tick is taken as soon as the result is registered, even if out_ch stalls
// a tick waits in the final step while the previous result has not been taken
// reset is asynchronous; state and counters clear, registers take defaults; divider datapath is not reset
module tick_rpm_meter_debounced (
  input  logic       clk_i,
  input  logic       rst_ni,
  tach_in_if.sink    in_ch,
  tach_out_if.source out_ch,
  tach_cfg_if.sink   cfg_ch
);
  import tach_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_SPD,
    ST_DIV_AVG,
    ST_DONE
  } state_e;

  state_e           state_q;
  cfg_t             cfg;
  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [SPD_W-1:0] div_quo;

  logic [CNT_W-1:0] period_q;
  logic [CNT_W-1:0] debounce_q;
  logic [SPD_W-1:0] speed_q;
  logic [SPD_W-1:0] avg_q;
  logic             pulse_q;

  logic             out_valid_q;
  logic [SPD_W-1:0] out_speed_q;
  logic [SPD_W-1:0] out_avg_q;
  logic             out_pulse_q;
  logic             out_idle_q;

  logic             in_xfer;
  logic             pulse_now;
  logic             out_free;
  logic [CNT_W-1:0] period_eff;
  logic             idle_now;

  tach_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  tach_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // handshake and decisions
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign pulse_now   = in_ch.sensor_low && (debounce_q >= cfg.debounce_ticks);
  assign out_free    = !out_valid_q || out_ch.ready;
  assign period_eff  = pulse_q ? '0 : period_q;
  assign idle_now    = period_eff >= cfg.idle_ticks;

  // divider launch: scale / period (period zero divides by one), then (2*avg + speed) / 3
  always_comb begin
    div_req = '0;
    if (state_q == ST_IDLE) begin
      div_req.start    = in_xfer && pulse_now;
      div_req.dividend = {2'b00, cfg.speed_scale};
      div_req.divisor  = (period_q == '0) ? CNT_W'(1) : period_q;
    end else if (state_q == ST_DIV_SPD) begin
      div_req.start    = div_stat.done;
      div_req.dividend = {1'b0, avg_q, 1'b0} + {2'b00, div_quo};
      div_req.divisor  = AVG_DIVISOR;
    end
  end

  // sequencer, tachometer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= '0;
      debounce_q  <= '0;
      speed_q     <= '0;
      avg_q       <= '0;
      pulse_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_speed_q <= '0;
      out_avg_q   <= '0;
      out_pulse_q <= 1'b0;
      out_idle_q  <= 1'b0;
    end else begin
      // result register fills from the final step, empties on a transfer
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            pulse_q <= pulse_now;
            if (pulse_now) begin
              debounce_q <= '0;
              state_q    <= ST_DIV_SPD;
            end else begin
              if (debounce_q != '1) begin
                debounce_q <= debounce_q + 1'b1;
              end
              state_q <= ST_DONE;
            end
          end
        end
        ST_DIV_SPD: begin
          if (div_stat.done) begin
            speed_q <= div_quo;
            state_q <= ST_DIV_AVG;
          end
        end
        ST_DIV_AVG: begin
          if (div_stat.done) begin
            avg_q   <= div_quo;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            if (idle_now) begin
              period_q    <= '0;
              speed_q     <= '0;
              avg_q       <= avg_q >> 2;
              out_speed_q <= '0;
              out_avg_q   <= avg_q >> 2;
            end else begin
              period_q    <= period_eff + 1'b1;
              out_speed_q <= speed_q;
              out_avg_q   <= avg_q;
            end
            out_pulse_q <= pulse_q;
            out_idle_q  <= idle_now;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.speed_x100     = out_speed_q;
  assign out_ch.avg_speed_x100 = out_avg_q;
  assign out_ch.pulse_taken    = out_pulse_q;
  assign out_ch.idle_hit       = out_idle_q;

  // checks
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV_SPD || state_q == ST_DIV_AVG))
    else $error("divider finished outside a divide step");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.idle_hit |-> out_ch.speed_x100 == '0)
    else $error("idle result with nonzero speed");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != ST_IDLE)
    else $error("tick accepted without leaving idle");

endmodule

/* src/tach_cfg.sv */
// configuration register file: debounce limit, idle limit, speed scale
// depends on tach_pkg and tach_cfg_if
module tach_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  tach_cfg_if.sink        cfg_ch,
  output tach_pkg::cfg_t  cfg_o
);
  import tach_pkg::*;

  cfg_t cfg_q;

  // always ready; unknown indexes are dropped
  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DEBOUNCE_RST;
      cfg_q.idle_ticks     <= IDLE_RST;
      cfg_q.speed_scale    <= SCALE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_ch.data[CNT_W-1:0];
        REG_IDLE:     cfg_q.idle_ticks     <= cfg_ch.data[CNT_W-1:0];
        REG_SCALE:    cfg_q.speed_scale    <= cfg_ch.data[SPD_W-1:0];
        default:      ;
      endcase
    end
  end

endmodule

/* src/tach_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
// depends on tach_pkg; shared by the speed and the average computation
module tach_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tach_pkg::div_req_t         req_i,
  output tach_pkg::div_stat_t        stat_o,
  output logic [tach_pkg::SPD_W-1:0] quo_o
);
  import tach_pkg::*;

  logic [DIV_W-1:0]     quo_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [CNT_W:0]       shifted;
  logic [CNT_W:0]       diff;
  logic                 ge;

  // one trial subtraction per cycle
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q[SPD_W-1:0];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out the top as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

endmodule

/* bench/tick_rpm_meter_debounced_tb.sv */
// self-checking bench for the debounced period tachometer: directed script, random
// pulse trains, a quiet stretch and an output hold-off, scored by a tick predictor
// depends on tach_pkg, tach_if and tick_rpm_meter_debounced
module tick_rpm_meter_debounced_tb;
  import tach_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int QUIET_TICKS    = 24;

  typedef struct packed {
    logic [SPD_W-1:0] speed;
    logic [SPD_W-1:0] avg;
    logic             pulse;
    logic             idle;
  } reading_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;
  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  low;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  has_fixed;
    reading_t              fixed;
  } script_row_t;

  localparam reading_t NO_FIXED = '0;

  logic clk_i;
  logic rst_ni;

  tach_in_if  in_ch();
  tach_out_if out_ch();
  tach_cfg_if cfg_ch();

  tick_rpm_meter_debounced uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // directed script: extremes, zero limits, zero scale, ignored index
  script_row_t tick_script [24] = '{
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0, 1'b1, '{24'd0, 24'd0, 1'b0, 1'b0}},
    '{ROW_TICK,  1'b0, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_WRITE, 1'b0, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_WRITE, 1'b0, REG_SCALE,    24'hFFFFFF,   1'b0, NO_FIXED},
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0, 1'b1,
      '{24'd8388607, 24'd2796202, 1'b1, 1'b0}},
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_WRITE, 1'b0, REG_IDLE,     24'd1,        1'b0, NO_FIXED},
    '{ROW_TICK,  1'b0, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    // pulse right after a timeout: zero period gives the full scale
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_WRITE, 1'b0, REG_IDLE,     24'd0,        1'b0, NO_FIXED},
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_TICK,  1'b0, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_WRITE, 1'b0, REG_SCALE,    24'd0,        1'b0, NO_FIXED},
    '{ROW_WRITE, 1'b0, REG_IDLE,     24'h00FFFF,   1'b0, NO_FIXED},
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_WRITE, 1'b0, REG_UNUSED,   24'h5A5A5A,   1'b0, NO_FIXED},
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_WRITE, 1'b0, REG_DEBOUNCE, 24'h00FFFF,   1'b0, NO_FIXED},
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    // upper data bits are dropped for a 16-bit register
    '{ROW_WRITE, 1'b0, REG_DEBOUNCE, 24'hFF0003,   1'b0, NO_FIXED},
    '{ROW_WRITE, 1'b0, REG_SCALE,    24'd6000000,  1'b0, NO_FIXED},
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_TICK,  1'b0, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED},
    '{ROW_TICK,  1'b1, REG_DEBOUNCE, 24'd0,        1'b0, NO_FIXED}
  };

  // predictor registers and state
  logic [CNT_W-1:0] deb_lim  = DEBOUNCE_RST;
  logic [CNT_W-1:0] idle_lim = IDLE_RST;
  logic [SPD_W-1:0] scale    = SCALE_RST;
  logic [CNT_W-1:0] per_cnt  = '0;
  logic [CNT_W-1:0] deb_cnt  = '0;
  logic [SPD_W-1:0] spd_val  = '0;
  logic [SPD_W-1:0] avg_val  = '0;

  reading_t pending_readings [$];

  int src_gap_pct     = 0;
  int snk_stall_pct   = 0;
  bit hold_pending    = 1'b0;
  int err_count       = 0;
  int ticks_sent      = 0;
  int pulses_seen     = 0;
  int timeouts_seen   = 0;
  int writes_done     = 0;
  int results_checked = 0;
  int quiet_cycles    = 0;

  // clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // one tick of the tachometer: debounce, period divide, average, idle timeout
  function automatic reading_t predict_tick(input logic low);
    reading_t         r;
    logic [SPD_W+1:0] sum;
    r = '0;
    if (low && deb_cnt >= deb_lim) begin
      spd_val = (per_cnt == '0) ? scale : scale / per_cnt;
      sum     = {avg_val, 1'b0} + spd_val;
      avg_val = SPD_W'(sum / 3);
      per_cnt = '0;
      deb_cnt = '0;
      r.pulse = 1'b1;
    end else if (deb_cnt != '1) begin
      deb_cnt = deb_cnt + 1'b1;
    end
    if (per_cnt >= idle_lim) begin
      spd_val = '0;
      avg_val = avg_val >> 2;
      per_cnt = '0;
      r.idle  = 1'b1;
    end else begin
      per_cnt = per_cnt + 1'b1;
    end
    r.speed = spd_val;
    r.avg   = avg_val;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch in %s at result %0d: got %0d, want %0d",
               what, results_checked, got, want);
  endtask

  task automatic set_mode(input idle_mode_e m);
    src_gap_pct   = (m == IDLE_SRC) ? 48 : (m == IDLE_BOTH) ? 19 : 0;
    snk_stall_pct = (m == IDLE_SNK) ? 48 : (m == IDLE_BOTH) ? 19 : 0;
  endtask

  // offer one tick, wait for its transfer, queue the predicted reading
  task automatic send_tick(input logic low, input logic has_fixed, input reading_t fixed);
    reading_t predicted;
    while ($urandom_range(99) < src_gap_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.sensor_low <= low;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = predict_tick(low);
    ticks_sent++;
    if (predicted.pulse) pulses_seen++;
    if (predicted.idle) timeouts_seen++;
    pending_readings.push_back(has_fixed ? fixed : predicted);
  endtask

  // stop offering ticks and let every expected reading come out
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_DEBOUNCE: deb_lim  = data[CNT_W-1:0];
      REG_IDLE:     idle_lim = data[CNT_W-1:0];
      REG_SCALE:    scale    = data[SPD_W-1:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // sensor stream: pulse trains spaced near the debounce limit, with bounce and noise
  task automatic run_stream(input int n);
    int   space_left;
    int   base;
    int   i;
    logic low;
    space_left = 0;
    base = (deb_lim > 20) ? 20 : int'(deb_lim);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        low = 1'($urandom_range(1));
      end else if (space_left > 0) begin
        low = 1'b0;
        space_left--;
      end else begin
        low = 1'b1;
        // zero spacing gives a bounce right after the edge
        space_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(base, base + 12);
      end
      send_tick(low, 1'b0, NO_FIXED);
    end
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // result check against the oldest expected reading
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.speed_x100 !== want.speed)
          report_mismatch("speed_x100", 32'(out_ch.speed_x100), 32'(want.speed));
        if (out_ch.avg_speed_x100 !== want.avg)
          report_mismatch("avg_speed_x100", 32'(out_ch.avg_speed_x100), 32'(want.avg));
        if (out_ch.pulse_taken !== want.pulse)
          report_mismatch("pulse_taken", 32'(out_ch.pulse_taken), 32'(want.pulse));
        if (out_ch.idle_hit !== want.idle)
          report_mismatch("idle_hit", 32'(out_ch.idle_hit), 32'(want.idle));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("tick_rpm_meter_debounced_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int                p;
    int                i;
    logic [CNT_W-1:0]  deb;
    logic [CNT_W-1:0]  idl;
    logic [SPD_W-1:0]  scl;

    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.sensor_low = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_DEBOUNCE;
    cfg_ch.data      = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed script
    set_mode(IDLE_NONE);
    for (i = 0; i < $size(tick_script); i++) begin
      if (tick_script[i].kind == ROW_WRITE)
        write_reg(tick_script[i].idx, tick_script[i].data);
      else
        send_tick(tick_script[i].low, tick_script[i].has_fixed, tick_script[i].fixed);
    end

    // random phases over the idling patterns and register settings
    for (p = 0; p < 8; p++) begin
      deb = (p == 2) ? 16'd0 : 16'($urandom_range(1, 10));
      idl = (p == 5) ? 16'd0 : (p == 6) ? 16'hFFFF : 16'($urandom_range(4, 64));
      scl = (p == 3) ? 24'd0 : (p == 4) ? 24'hFFFFFF : 24'($urandom_range(1, 24'hFFFFFF));
      write_reg(REG_DEBOUNCE, {8'($urandom_range(255)), deb});
      write_reg(REG_IDLE, {8'($urandom_range(255)), idl});
      write_reg(REG_SCALE, scl);
      set_mode(idle_mode_e'(p % 4));
      run_stream(48);
    end

    // output held off while ticks keep coming, so the input stalls
    write_reg(REG_DEBOUNCE, 24'd2);
    write_reg(REG_IDLE, 24'd30);
    set_mode(IDLE_NONE);
    hold_pending = 1'b1;
    run_stream(40);

    // quiet stretch under the top debounce limit: idle fires, low samples are refused
    write_reg(REG_DEBOUNCE, 24'h00FFFF);
    write_reg(REG_IDLE, 24'd20);
    write_reg(REG_SCALE, 24'($urandom_range(1, 24'hFFFFFF)));
    for (i = 0; i < QUIET_TICKS; i++) send_tick(1'b0, 1'b0, NO_FIXED);
    send_tick(1'b1, 1'b0, NO_FIXED);
    send_tick(1'b1, 1'b0, NO_FIXED);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d ticks with %0d debounced pulses and %0d idle timeouts",
             ticks_sent, pulses_seen, timeouts_seen);
    $display("%0d register writes, %0d results compared", writes_done, results_checked);
    if (err_count == 0) begin
      $display("tick_rpm_meter_debounced_tb: clean");
    end else begin
      $display("tick_rpm_meter_debounced_tb: errors");
    end
    $finish;
  end

endmodule
